FILE: design/iir_dfo_pkg.sv
// Shared types, constants and helpers for the direct form one IIR filter.
// Used by the interfaces, the multiplier, the register file and the top level.
package iir_dfo_pkg;

	localparam int SAMPLE_W    = 24;
	localparam int COEF_W      = 32;
	localparam int NUM_FF_TAPS = 3;
	localparam int NUM_POLES   = 3;

	// one scaling product, then the feed-forward taps, then the feedback taps
	localparam int NUM_OPS = 1 + NUM_FF_TAPS + NUM_POLES - 1;
	localparam int OP_W    = $clog2(NUM_OPS);

	localparam int DIGIT_W = 8;
	localparam int NDIG    = (SAMPLE_W + DIGIT_W - 1) / DIGIT_W;
	localparam int MPL_W   = NDIG * DIGIT_W;
	localparam int CNT_W   = $clog2(NDIG + 1);
	localparam int PROD_W  = SAMPLE_W + COEF_W;
	localparam int PACC_W  = MPL_W + COEF_W;

	localparam int ACC_W    = 64;
	localparam int SCALE_SH = 24;
	localparam int ACC_SH   = 30;
	localparam int XR_W     = PROD_W - SCALE_SH + 1;
	localparam int YR_W     = ACC_W - ACC_SH + 1;

	localparam int XH_D = (NUM_FF_TAPS > 1) ? NUM_FF_TAPS - 1 : 1;
	localparam int YH_D = (NUM_POLES > 1) ? NUM_POLES - 1 : 1;

	localparam int CFG_IDX_W = 3;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [ACC_W-1:0]    acc_t;
	typedef logic [OP_W-1:0]            op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FF_D0,
		REG_FF_D1,
		REG_FF_D2,
		REG_FB_D1,
		REG_FB_D2,
		REG_INV_GAIN
	} cfg_reg_t;

	localparam coef_t FF_D0_RESET    = 32'sh4000_0000;
	localparam coef_t INV_GAIN_RESET = 32'sh0100_0000;

	localparam acc_t SAT_HI  = (64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1;
	localparam acc_t SAT_LO  = -SAT_HI - 64'sd1;
	localparam acc_t ACC_MAX = 64'sh7fff_ffff_ffff_ffff;
	localparam acc_t ACC_MIN = 64'sh8000_0000_0000_0000;

	typedef struct packed {
		logic    start;
		coef_t   mcand;
		sample_t mplier;
	} mul_ctrl_t;

	// {clip, value} of v clamped to the sample range
	function automatic logic [SAMPLE_W:0] sat_sample(input acc_t v);
		logic [SAMPLE_W:0] r;
		if (v > SAT_HI) begin
			r = {1'b1, SAT_HI[SAMPLE_W-1:0]};
		end else if (v < SAT_LO) begin
			r = {1'b1, SAT_LO[SAMPLE_W-1:0]};
		end else begin
			r = {1'b0, v[SAMPLE_W-1:0]};
		end
		return r;
	endfunction

endpackage

FILE: design/iir_dfo_if.sv
// Valid/ready channel interfaces for the sample input and the filtered output.
// Depends on iir_dfo_pkg for the sample type.
interface iir_dfo_in_if import iir_dfo_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface iir_dfo_out_if import iir_dfo_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample_out;
	logic    clipped;

	modport source (output valid, output sample_out, output clipped, input ready);
	modport sink (input valid, input sample_out, input clipped, output ready);
endinterface

FILE: design/iir_dfo_mul.sv
// Digit-serial signed multiplier: coefficient times sample, MSB digit first.
// Depends on iir_dfo_pkg; one digit per cycle, product valid with done.
module iir_dfo_mul import iir_dfo_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  mul_ctrl_t ctrl,
	output logic      done,
	output prod_t     prod
);

	coef_t                     mcand_q;
	logic [MPL_W-1:0]          sh_q;
	logic signed [PACC_W-1:0]  prod_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      done_q;
	logic                      first;
	logic signed [DIGIT_W:0]   dig;
	logic signed [COEF_W+DIGIT_W:0] part;

	assign first = (cnt_q == CNT_W'(NDIG));
	// top digit carries the sign, the rest are unsigned
	assign dig   = first ? {sh_q[MPL_W-1], sh_q[MPL_W-1 -: DIGIT_W]}
	                     : {1'b0, sh_q[MPL_W-1 -: DIGIT_W]};
	assign part  = mcand_q * dig;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				cnt_q <= CNT_W'(NDIG);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - CNT_W'(1);
				done_q <= (cnt_q == CNT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			mcand_q <= ctrl.mcand;
			sh_q    <= MPL_W'(ctrl.mplier);
		end else if (cnt_q != '0) begin
			sh_q <= sh_q << DIGIT_W;
			if (first) begin
				prod_q <= PACC_W'(part);
			end else begin
				prod_q <= (prod_q <<< DIGIT_W) + PACC_W'(part);
			end
		end
	end

	assign done = done_q;
	assign prod = prod_q[PROD_W-1:0];

endmodule

FILE: design/iir_dfo_cfg.sv
// Coefficient and gain registers with write decode and per-step selection.
// Depends on iir_dfo_pkg for the register codes and the step numbering.
module iir_dfo_cfg import iir_dfo_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COEF_W-1:0]    cfg_wdata,
	input  op_t                  sel_op,
	output coef_t                coef
);

	coef_t ff0_q, ff1_q, ff2_q, fb1_q, fb2_q, inv_q;
	op_t   kf, kb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ff0_q <= FF_D0_RESET;
			ff1_q <= '0;
			ff2_q <= '0;
			fb1_q <= '0;
			fb2_q <= '0;
			inv_q <= INV_GAIN_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FF_D0:    ff0_q <= cfg_wdata;
				REG_FF_D1:    ff1_q <= cfg_wdata;
				REG_FF_D2:    ff2_q <= cfg_wdata;
				REG_FB_D1:    fb1_q <= cfg_wdata;
				REG_FB_D2:    fb2_q <= cfg_wdata;
				REG_INV_GAIN: inv_q <= cfg_wdata;
				default:      ;
			endcase
		end
	end

	assign kf = sel_op - OP_W'(1);
	assign kb = sel_op - OP_W'(NUM_FF_TAPS);

	// step 0 scales, then feed-forward taps, then feedback taps; others are zero
	always_comb begin
		coef = '0;
		if (sel_op == '0) begin
			coef = inv_q;
		end else if (sel_op <= OP_W'(NUM_FF_TAPS)) begin
			if (kf == '0) begin
				coef = ff0_q;
			end else if (NUM_FF_TAPS > 1 && kf == OP_W'(1)) begin
				coef = ff1_q;
			end else if (NUM_FF_TAPS > 2 && kf == OP_W'(2)) begin
				coef = ff2_q;
			end
		end else begin
			if (NUM_POLES > 1 && kb == OP_W'(1)) begin
				coef = fb1_q;
			end else if (NUM_POLES > 2 && kb == OP_W'(2)) begin
				coef = fb2_q;
			end
		end
	end

endmodule

FILE: design/iir_filter_direct_form_one_unit.sv
// Direct form one IIR filter (biquad at package sizes), fixed point.
// Depends on iir_dfo_pkg, iir_dfo_if, iir_dfo_mul and iir_dfo_cfg.
//
// Usage:
//   samples  : valid/ready input channel, one signed sample per item.
//   filtered : valid/ready output channel, one filtered sample and a
//              clipped flag per input item, in order.
//   cfg_*    : write-only register port (index 0..5: ff_d0, ff_d1, ff_d2,
//              fb_d1, fb_d2, inv_gain); write only while the filter is idle.
// Each item runs six products (input scaling, three feed-forward taps, two
// feedback taps) through one digit-serial 32x9 multiplier, three 8-bit
// digits per product after the operands are loaded. An input is accepted
// only while the filter is idle, so a new input waits until the previous
// item has passed its result to the output register. The output register
// lets the next item start while a result waits; if the receiver still
// stalls when the next result is ready, the filter holds that result and
// accepts nothing until the output register frees up.
// Reset clears both delay lines and loads the default coefficients
// (unity feed-forward, unity gain).
module iir_filter_direct_form_one_unit import iir_dfo_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	iir_dfo_in_if.sink           samples,
	iir_dfo_out_if.source        filtered,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COEF_W-1:0]    cfg_wdata
);

	typedef enum logic [1:0] {IDLE, RUN, FIN} state_t;

	state_t  state_q;
	op_t     op_q;
	acc_t    acc_q;
	sample_t x0_q;
	logic    sat_q;
	sample_t xh_q [XH_D];
	sample_t yh_q [YH_D];
	sample_t out_smp_q;
	logic    out_clip_q;
	logic    out_valid_q;

	mul_ctrl_t mul_ctrl;
	logic      mul_done;
	prod_t     mul_prod;
	op_t       op_nx;
	op_t       sel_op;
	coef_t     coef;
	sample_t   hist_c;
	logic      last_op;
	logic      neg_term;
	logic      accept;
	logic      out_load;

	logic signed [XR_W-1:0]  xr;
	logic [SAMPLE_W:0]       x0_sat;
	logic signed [YR_W-1:0]  yr;
	logic [SAMPLE_W:0]       y_sat;
	logic signed [ACC_W:0]   term;
	logic signed [ACC_W+1:0] sum;
	logic                    acc_ov;
	acc_t                    acc_add;

	assign accept   = samples.valid && samples.ready;
	assign op_nx    = op_q + OP_W'(1);
	assign sel_op   = (state_q == RUN) ? op_nx : '0;
	assign last_op  = (op_q == OP_W'(NUM_OPS - 1));
	assign neg_term = (op_q > OP_W'(NUM_FF_TAPS));
	assign out_load = (state_q == FIN) && (!out_valid_q || filtered.ready);

	iir_dfo_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.sel_op    (sel_op),
		.coef      (coef)
	);

	// scaled input: round to nearest, ties up, then clamp
	assign xr     = XR_W'(mul_prod >>> SCALE_SH) + XR_W'(mul_prod[SCALE_SH-1]);
	assign x0_sat = sat_sample(ACC_W'(xr));

	assign yr    = YR_W'(acc_q >>> ACC_SH) + YR_W'(acc_q[ACC_SH-1]);
	assign y_sat = sat_sample(ACC_W'(yr));

	assign term    = neg_term ? -((ACC_W+1)'(mul_prod)) : (ACC_W+1)'(mul_prod);
	assign sum     = (ACC_W+2)'(acc_q) + (ACC_W+2)'(term);
	assign acc_ov  = (sum[ACC_W+1:ACC_W-1] != 3'b000) && (sum[ACC_W+1:ACC_W-1] != 3'b111);
	assign acc_add = acc_ov ? (sum[ACC_W+1] ? ACC_MIN : ACC_MAX) : sum[ACC_W-1:0];

	always_comb begin
		hist_c = '0;
		for (int i = 0; i < XH_D; i++) begin
			if (i < NUM_FF_TAPS - 1 && op_nx == OP_W'(i + 2)) begin
				hist_c = xh_q[i];
			end
		end
		for (int i = 0; i < YH_D; i++) begin
			if (i < NUM_POLES - 1 && op_nx == OP_W'(i + NUM_FF_TAPS + 1)) begin
				hist_c = yh_q[i];
			end
		end
	end

	always_comb begin
		mul_ctrl.start  = accept || (state_q == RUN && mul_done && !last_op);
		mul_ctrl.mcand  = coef;
		if (state_q == IDLE) begin
			mul_ctrl.mplier = samples.sample_in;
		end else if (op_q == '0) begin
			mul_ctrl.mplier = x0_sat[SAMPLE_W-1:0];
		end else begin
			mul_ctrl.mplier = hist_c;
		end
	end

	iir_dfo_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mul_ctrl),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			op_q        <= '0;
			acc_q       <= '0;
			x0_q        <= '0;
			sat_q       <= 1'b0;
			out_smp_q   <= '0;
			out_clip_q  <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < XH_D; i++) begin
				xh_q[i] <= '0;
			end
			for (int i = 0; i < YH_D; i++) begin
				yh_q[i] <= '0;
			end
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (filtered.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						op_q    <= '0;
						sat_q   <= 1'b0;
						state_q <= RUN;
					end
				end
				RUN: begin
					if (mul_done) begin
						if (op_q == '0) begin
							x0_q  <= x0_sat[SAMPLE_W-1:0];
							sat_q <= sat_q | x0_sat[SAMPLE_W];
						end else if (op_q == OP_W'(1)) begin
							acc_q <= ACC_W'(mul_prod);
						end else begin
							acc_q <= acc_add;
							sat_q <= sat_q | acc_ov;
						end
						if (last_op) begin
							state_q <= FIN;
						end else begin
							op_q <= op_nx;
						end
					end
				end
				FIN: begin
					if (out_load) begin
						out_smp_q   <= y_sat[SAMPLE_W-1:0];
						out_clip_q  <= sat_q | y_sat[SAMPLE_W];
						for (int i = XH_D - 1; i > 0; i--) begin
							xh_q[i] <= xh_q[i-1];
						end
						xh_q[0] <= x0_q;
						for (int i = YH_D - 1; i > 0; i--) begin
							yh_q[i] <= yh_q[i-1];
						end
						yh_q[0] <= y_sat[SAMPLE_W-1:0];
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign samples.ready       = (state_q == IDLE);
	assign filtered.valid      = out_valid_q;
	assign filtered.sample_out = out_smp_q;
	assign filtered.clipped    = out_clip_q;

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == RUN && op_q == '0))
		else $error("accepted item did not start the product sequence");

	a_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == RUN))
		else $error("multiplier finished outside the product sequence");

	a_op_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == RUN) |-> (op_q <= OP_W'(NUM_OPS - 1)))
		else $error("product step out of range");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(filtered.valid) |-> ($past(state_q) == FIN))
		else $error("output loaded without a finished item");
`endif

endmodule
